/* src/pxh_pkg.sv */
// ----------------------------------------------------------------------------
// Pixel histogram range package
// Shared widths and constants for the pixel value presence scan.
// ----------------------------------------------------------------------------
package pxh_pkg;

   localparam int PIXEL_W   = 8;
   localparam int NUM_VALUES = 1 << PIXEL_W;
   localparam int COUNT_W   = PIXEL_W + 1;

   typedef logic [PIXEL_W-1:0]    pixel_type;
   typedef logic [COUNT_W-1:0]    count_type;
   typedef logic [NUM_VALUES-1:0] seen_type;

   localparam pixel_type TOP_VALUE = pixel_type'(NUM_VALUES - 1);

endpackage

/* src/pixel_histogram_color_range.sv */
// ----------------------------------------------------------------------------
// Pixel histogram color range
// Records which pixel values occur in a frame and reports their range.
// ----------------------------------------------------------------------------
// Pixels arrive on the req_ channel, one per transfer, with req_frame_end
// high on the last pixel of a frame. Outside a scan req_stall is low, so
// a frame streams in at one pixel per cycle. Every pixel sets one presence
// bit in a 256-bit shift register.
// The transfer that carries req_frame_end starts a scan: the register shifts
// right once per cycle, and a shared increment and compare unit looks at its
// lowest bit to build the distinct count, lowest and highest value. Zeros
// shift in from the top, so the scan leaves the register clear.
// req_stall is high for the whole scan. The edge that takes in the last
// bit also loads the rsp_ output register and raises rsp_valid, so the
// next frame may start in the following cycle, while the result still
// waits. A frame's last pixel thus blocks the input until its scan has
// ended. If the receiver holds rsp_stall, a later scan stops on its last
// bit until the pending result has been transferred.
// Synchronous reset clears the presence bits, the sequencer and rsp_valid.
// ----------------------------------------------------------------------------
module pixel_histogram_color_range
   import pxh_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [PIXEL_W-1:0]  req_pixel,
   input  logic                req_frame_end,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [COUNT_W-1:0]  rsp_distinct_count,
   output logic [PIXEL_W-1:0]  rsp_lowest_value,
   output logic [PIXEL_W-1:0]  rsp_highest_value
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic      state_ff, state_in;
   seen_type  seen_ff, seen_in;
   pixel_type idx_ff, idx_in;
   count_type count_ff, count_in;
   pixel_type low_ff, low_in;
   pixel_type high_ff, high_in;
   logic      any_ff, any_in;
   logic      rsp_valid_ff, rsp_valid_in;
   count_type rsp_count_ff, rsp_count_in;
   pixel_type rsp_low_ff, rsp_low_in;
   pixel_type rsp_high_ff, rsp_high_in;

   logic      req_xfer;
   logic      rsp_xfer;
   logic      bit_seen;
   logic      scan_last;
   logic      out_free;
   count_type step_count;
   pixel_type step_low;
   pixel_type step_high;
   logic      step_any;

   assign req_stall = (state_ff == ST_SCAN);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || rsp_xfer;

   // Shared scan unit: the lowest presence bit updates count and range.
   always_comb begin
      bit_seen   = seen_ff[0];
      scan_last  = (idx_ff == TOP_VALUE);
      step_count = count_ff;
      step_low   = low_ff;
      step_high  = high_ff;
      step_any   = any_ff;
      if (bit_seen) begin
         step_count = count_ff + count_type'(1);
         if (!any_ff) begin
            step_low = idx_ff;
         end
         step_high = idx_ff;
         step_any  = 1'b1;
      end
   end

   // Sequencer, presence bits and output register.
   always_comb begin
      state_in     = state_ff;
      seen_in      = seen_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      any_in       = any_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;
      rsp_count_in = rsp_count_ff;
      rsp_low_in   = rsp_low_ff;
      rsp_high_in  = rsp_high_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               seen_in[req_pixel] = 1'b1;
               if (req_frame_end) begin
                  state_in = ST_SCAN;
                  idx_in   = '0;
                  count_in = '0;
                  low_in   = TOP_VALUE;
                  high_in  = '0;
                  any_in   = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (!scan_last) begin
               idx_in   = idx_ff + pixel_type'(1);
               seen_in  = {1'b0, seen_ff[NUM_VALUES-1:1]};
               count_in = step_count;
               low_in   = step_low;
               high_in  = step_high;
               any_in   = step_any;
            end else if (out_free) begin
               // Last bit: publish the result; the final shift empties the vector.
               rsp_valid_in = 1'b1;
               rsp_count_in = step_count;
               rsp_low_in   = step_low;
               rsp_high_in  = step_high;
               seen_in      = {1'b0, seen_ff[NUM_VALUES-1:1]};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state with synchronous reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Scan accumulators and result payload.
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      count_ff     <= count_in;
      low_ff       <= low_in;
      high_ff      <= high_in;
      any_ff       <= any_in;
      rsp_count_ff <= rsp_count_in;
      rsp_low_ff   <= rsp_low_in;
      rsp_high_ff  <= rsp_high_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_distinct_count = rsp_count_ff;
   assign rsp_lowest_value   = rsp_low_ff;
   assign rsp_highest_value  = rsp_high_ff;

   // A result is only published at the end of a scan.
   a_rsp_after_scan: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && rsp_valid_in) |-> (state_ff == ST_SCAN && scan_last))
      else $error("result published outside the end of a scan");

   // Every frame holds at least one pixel, so a result never counts zero.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff != '0))
      else $error("result with zero distinct values");

   // The range is ordered whenever a result is presented.
   a_range_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_low_ff <= rsp_high_ff))
      else $error("lowest value above highest value");

   // Leaving the scan clears every presence bit.
   a_clear_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && state_in == ST_IDLE) |=> (seen_ff == '0))
      else $error("presence bits not cleared after a frame");

   // The scan count never exceeds the number of bits visited so far.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (count_ff <= {1'b0, idx_ff}))
      else $error("scan count runs ahead of the scan index");

endmodule
